// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL, empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/civ_pkg.sv
// Types, constants and calendar tables for the date-to-epoch converter.
package civ_pkg;

   localparam int REQ_W   = 40;
   localparam int RSP_W   = 40;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int EPOCH_W = 39;
   localparam int DAYS_W  = 22;
   localparam int HMS_W   = 17;
   localparam int MUL_A_W = 14;
   localparam int MUL_B_W = 13;
   localparam int MUL_P_W = 27;
   localparam int QUOT_W  = 8;
   localparam int Q400_W  = 6;
   localparam int RECIP_SHIFT = 19;

   // floor(n/100) == (n * 5243) >> 19 for every n below 2**14
   localparam logic [MUL_B_W-1:0] RECIP_100     = 13'd5243;
   localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 13'd365;
   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 14'd1970;
   localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
   // leap years in 1..1969
   localparam logic [DAYS_W-1:0]  LEAPS_TO_EPOCH = 22'd477;
   localparam logic [HMS_W-1:0]   SECS_PER_DAY   = 17'd86400;
   localparam logic [HMS_W-1:0]   SECS_PER_HOUR  = 17'd3600;
   localparam logic [HMS_W-1:0]   SECS_PER_MIN   = 17'd60;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX      = 39'd253402300799;

   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
   localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
   localparam logic [MIN_W-1:0]   MINSEC_MAX = 6'd59;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q100Y,
      ST_Q100P,
      ST_Q400P,
      ST_Y365,
      ST_DAYS,
      ST_SCALE,
      ST_SUM
   } civ_state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_Q100Y,
      CMD_Q100P,
      CMD_Q400P,
      CMD_Y365,
      CMD_DAYS,
      CMD_SCALE,
      CMD_OUT
   } civ_cmd_type;

   // length of a month in a common year; nonsense months read zero
   function automatic logic [DAY_W-1:0] civ_month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of month m in a common year
   function automatic logic [8:0] civ_days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/core/civ_ctrl.sv
// Sequencer for the date-to-epoch converter: steps the datapath, owns handshakes.
module civ_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output civ_pkg::civ_cmd_type cmd
);
   import civ_pkg::*;

   civ_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_Q100Y;
         ST_Q100Y: state_in = ST_Q100P;
         ST_Q100P: state_in = ST_Q400P;
         ST_Q400P: state_in = ST_Y365;
         ST_Y365:  state_in = ST_DAYS;
         ST_DAYS:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SUM;
         ST_SUM:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd = CMD_LOAD;
         end
         ST_Q100Y: cmd = CMD_Q100Y;
         ST_Q100P: cmd = CMD_Q100P;
         ST_Q400P: cmd = CMD_Q400P;
         ST_Y365:  cmd = CMD_Y365;
         ST_DAYS:  cmd = CMD_DAYS;
         ST_SCALE: cmd = CMD_SCALE;
         ST_SUM:   if (out_free) cmd = CMD_OUT;
         default:  cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      if (cmd == CMD_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/core/civ_dp.sv
// Datapath for the date-to-epoch converter: field checks, day count, scaling.
module civ_dp (
   input  logic                          clock,
   input  civ_pkg::civ_cmd_type          cmd,
   input  logic [civ_pkg::REQ_W-1:0]     req_tdata,
   output logic [civ_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tuser
);
   import civ_pkg::*;

   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [HOUR_W-1:0]  hour_ff;
   logic [MIN_W-1:0]   minute_ff;
   logic [SEC_W-1:0]   second_ff;

   logic [HMS_W-1:0]   hms_ff, hms_in;
   logic [QUOT_W-1:0]  q100y_ff, q100p_ff;
   logic [Q400_W-1:0]  q400p_ff;
   logic [DAYS_W-1:0]  y365_ff;
   logic               leap_ff, leap_in;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic               invalid_ff, invalid_in;
   logic [EPOCH_W-1:0] prod_ff;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               inv_out_ff;

   logic [YEAR_W-1:0]  year_m1;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [QUOT_W-1:0]  quot;
   logic               century;
   logic [DAYS_W-1:0]  leaps;
   logic [DAY_W:0]     dim;
   logic               leap_adj;

   assign year_m1 = year_ff - 14'd1;

   // one shared constant multiplier, used by the division and year steps
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd)
         CMD_Q100Y: begin
            mul_a = year_ff;
            mul_b = RECIP_100;
         end
         CMD_Q100P: begin
            mul_a = year_m1;
            mul_b = RECIP_100;
         end
         CMD_Q400P: begin
            mul_a = {2'b00, year_m1[YEAR_W-1:2]};
            mul_b = RECIP_100;
         end
         CMD_Y365: begin
            mul_a = year_ff - EPOCH_YEAR;
            mul_b = DAYS_PER_YEAR;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign quot  = mul_p[RECIP_SHIFT +: QUOT_W];

   assign hms_in = HMS_W'(hour_ff) * SECS_PER_HOUR + HMS_W'(minute_ff) * SECS_PER_MIN
                 + HMS_W'(second_ff);

   // year divisible by 100 when q*100 gives it back
   assign century = (15'(q100y_ff) * 15'd100) == {1'b0, year_ff};
   assign leap_in = (year_ff[1:0] == 2'b00) && (!century || (q100y_ff[1:0] == 2'b00));

   assign leaps    = DAYS_W'(year_m1[YEAR_W-1:2]) - DAYS_W'(q100p_ff) + DAYS_W'(q400p_ff)
                   - LEAPS_TO_EPOCH;
   assign leap_adj = leap_ff && (month_ff > MONTH_FEB);
   assign days_in  = y365_ff + leaps + DAYS_W'(civ_days_before(month_ff))
                   + DAYS_W'(leap_adj) + DAYS_W'(day_ff) - 22'd1;

   assign dim = {1'b0, civ_month_len(month_ff)}
              + (DAY_W+1)'(leap_ff && (month_ff == MONTH_FEB));

   assign invalid_in = (year_ff < EPOCH_YEAR) || (year_ff > YEAR_MAX)
                    || (month_ff == '0) || (month_ff > MONTH_MAX)
                    || (day_ff == '0) || ({1'b0, day_ff} > dim)
                    || (hour_ff > HOUR_MAX) || (minute_ff > MINSEC_MAX)
                    || (second_ff > MINSEC_MAX);

   assign epoch_in = invalid_ff ? '1 : prod_ff + EPOCH_W'(hms_ff);

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         year_ff   <= req_tdata[13:0];
         month_ff  <= req_tdata[17:14];
         day_ff    <= req_tdata[22:18];
         hour_ff   <= req_tdata[27:23];
         minute_ff <= req_tdata[33:28];
         second_ff <= req_tdata[39:34];
      end
      if (cmd == CMD_Q100Y) begin
         q100y_ff <= quot;
         hms_ff   <= hms_in;
      end
      if (cmd == CMD_Q100P) q100p_ff <= quot;
      if (cmd == CMD_Q400P) q400p_ff <= quot[Q400_W-1:0];
      if (cmd == CMD_Y365) begin
         y365_ff <= mul_p[DAYS_W-1:0];
         leap_ff <= leap_in;
      end
      if (cmd == CMD_DAYS) begin
         days_ff    <= days_in;
         invalid_ff <= invalid_in;
      end
      if (cmd == CMD_SCALE) prod_ff <= EPOCH_W'(days_ff) * EPOCH_W'(SECS_PER_DAY);
      if (cmd == CMD_OUT) begin
         epoch_ff   <= epoch_in;
         inv_out_ff <= invalid_ff;
      end
   end

   assign rsp_tdata = {1'b0, epoch_ff};
   assign rsp_tuser = inv_out_ff;

endmodule

// File: rtl/core/civil_date_to_epoch_seconds.sv
// rsp_tvalid is registered: it rises as the sequencer leaves its last step and loads the output register.
// One transaction at a time: a request is taken only in idle, then runs the sequencer's 8-step pass through
// the shared constant multiplier (3 divisions by 100, year x 365) and the day scaling.
// A result waits in the output register while the next request runs; the next result stalls
// in the last step until that register empties.
// Reset (synchronous, active high) idles the sequencer and drops rsp_tvalid; datapath not reset.
`include "assert_macros.svh"

module civil_date_to_epoch_seconds (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
   input  logic [civ_pkg::REQ_W-1:0]     req_tdata,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // epoch_seconds[38:0] (signed), bit 39 zero pad
   output logic [civ_pkg::RSP_W-1:0]     rsp_tdata,
   // invalid[0]
   output logic                          rsp_tuser
);
   import civ_pkg::*;

   civ_cmd_type cmd;

   // Sequencer: one pass per transaction.
   //   idle  -> take request, latch fields
   //   q100y -> year/100 (leap test), h/m/s seconds
   //   q100p -> (year-1)/100
   //   q400p -> (year-1)/400
   //   y365  -> (year-1970)*365, leap flag
   //   days  -> total day count, range checks
   //   scale -> days*86400
   //   sum   -> add time of day, load output register when free
   civ_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: divisions by 100 and 400 are reciprocal multiplies on one
   // shared 14x13 multiplier; invalid dates force an all-ones epoch.
   civ_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // an invalid result always carries -1
   `ASSERT_IMPLY(a_invalid_all_ones, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[EPOCH_W-1:0] == '1)

   // a valid result stays within year 9999 and keeps the pad bit clear
   `ASSERT_IMPLY(a_valid_in_range, clock, reset, rsp_tvalid && !rsp_tuser,
      (rsp_tdata[EPOCH_W-1:0] <= EPOCH_MAX) && !rsp_tdata[RSP_W-1])

   // only one transaction in flight: taking a request closes the input
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
